// ----- src/drd_pkg.sv -----
`default_nettype none
package drd_pkg;

   localparam int MAX_NODES_DEFAULT = 32;

   localparam int KIND_W    = 2;
   localparam int NODE_W    = 5;
   localparam int PUSHED_W  = 6;
   localparam int ERR_W     = 2;
   localparam int ACTIVE_W  = 6;

   localparam int QUEUE_DEPTH = 32;
   localparam int QUEUE_AW    = 5;
   localparam int QUEUE_FW    = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd32;

   // register index, taken from paddr[2]
   localparam logic REG_ACTIVE_NODES = 1'b0;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ADD_EDGE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_POP      = 2'd3;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_DONE  = 2'd2;

   typedef struct packed {
      logic              load;
      logic              edge_rd;
      logic              edge_wr;
      logic              enq_src;
      logic              complete;
      logic              scan;
      logic              pop;
      logic              err_load;
      logic [ERR_W-1:0]  err_code;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              in_range;
      logic              edge_in_range;
      logic              node_done;
      logic              queue_empty;
      logic              scan_done;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- src/drd_ctrl.sv -----
`default_nettype none
module drd_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  drd_pkg::dp_status_type  status,
   output drd_pkg::dp_cmd_type     cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);
   import drd_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DECODE   = 9'b000000010,
      ST_EDGE_RD  = 9'b000000100,
      ST_EDGE_WR  = 9'b000001000,
      ST_ENQ      = 9'b000010000,
      ST_COMPLETE = 9'b000100000,
      ST_SCAN     = 9'b001000000,
      ST_POP      = 9'b010000000,
      ST_RESP     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            case (status.kind)
               KIND_ADD_EDGE: begin
                  if (status.edge_in_range) state_in = ST_EDGE_RD;
               end
               KIND_START: begin
                  if (status.in_range) state_in = ST_ENQ;
               end
               KIND_COMPLETE: begin
                  if (status.in_range && status.node_done) begin
                     cmd.err_load = 1'b1;
                     cmd.err_code = ERR_DONE;
                  end else if (status.in_range) begin
                     state_in = ST_COMPLETE;
                  end
               end
               default: begin
                  if (status.queue_empty) begin
                     cmd.err_load = 1'b1;
                     cmd.err_code = ERR_EMPTY;
                  end else begin
                     state_in = ST_POP;
                  end
               end
            endcase
         end
         ST_EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            cmd.edge_wr = 1'b1;
            state_in    = ST_RESP;
         end
         ST_ENQ: begin
            cmd.enq_src = 1'b1;
            state_in    = ST_RESP;
         end
         ST_COMPLETE: begin
            cmd.complete = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) state_in = ST_RESP;
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule
`default_nettype wire

// ----- src/drd_datapath.sv -----
`default_nettype none
module drd_datapath #(
   parameter int MAX_NODES = drd_pkg::MAX_NODES_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   input  drd_pkg::dp_cmd_type             cmd,
   output drd_pkg::dp_status_type          status,
   input  wire [drd_pkg::KIND_W-1:0]       req_kind,
   input  wire [drd_pkg::NODE_W-1:0]       req_node,
   input  wire [drd_pkg::NODE_W-1:0]       req_parent_node,
   input  wire [drd_pkg::ACTIVE_W-1:0]     active_nodes,
   output logic                            rsp_dispatch_valid,
   output logic [drd_pkg::NODE_W-1:0]      rsp_dispatch_node,
   output logic [drd_pkg::PUSHED_W-1:0]    rsp_pushed_count,
   output logic                            rsp_all_done,
   output logic [drd_pkg::ERR_W-1:0]       rsp_error
);
   import drd_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
   localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(MAX_NODES);
   localparam logic [MAX_NODES-1:0] ONE_HOT0 = MAX_NODES'(1);

   // latched request
   logic [KIND_W-1:0] kind_ff;
   logic [NODE_W-1:0] node_ff, parent_ff;
   logic [IDX_W-1:0]  node_idx, parent_idx;

   // graph state
   logic [MAX_NODES-1:0] matrix_mem [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff;
   logic [MAX_NODES-1:0] row_rdata_ff;
   logic                 row_rvalid_ff;
   logic [MAX_NODES-1:0] row;
   logic [IDX_W-1:0]     row_raddr;
   logic [MAX_NODES-1:0] mask_ff;
   logic [CNT_W-1:0]     count_ff;

   // scan pipeline
   logic [IDX_W:0]   scan_cnt_ff;
   logic             scan_issue;
   logic             eval_vld_ff;
   logic [IDX_W-1:0] eval_idx_ff;
   logic             scan_hit;

   // ready queue
   logic [NODE_W-1:0]   queue_mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] head_ff;
   logic [QUEUE_FW-1:0] fill_ff;
   logic [QUEUE_AW-1:0] tail;
   logic [NODE_W-1:0]   q_rdata_ff;
   logic                push_req, push_ok;
   logic [NODE_W-1:0]   push_id;

   // result registers
   logic                disp_vld_ff;
   logic [PUSHED_W-1:0] pushed_ff;
   logic [ERR_W-1:0]    err_ff;

   assign node_idx   = IDX_W'(node_ff);
   assign parent_idx = IDX_W'(parent_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         node_ff   <= req_node;
         parent_ff <= req_parent_node;
      end
   end

   // parent matrix, registered read
   assign row_raddr  = cmd.scan ? scan_cnt_ff[IDX_W-1:0] : node_idx;
   assign scan_issue = cmd.scan && (scan_cnt_ff < SCAN_END);
   assign row        = row_rvalid_ff ? row_rdata_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.edge_rd || scan_issue) begin
         row_rdata_ff  <= matrix_mem[row_raddr];
         row_rvalid_ff <= row_valid_ff[row_raddr];
      end
      if (cmd.edge_wr) begin
         matrix_mem[node_idx] <= row | (ONE_HOT0 << parent_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         mask_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (cmd.edge_wr) row_valid_ff[node_idx] <= 1'b1;
         if (cmd.complete) begin
            mask_ff[node_idx] <= 1'b1;
            count_ff          <= count_ff + CNT_W'(1);
         end
      end
   end

   // scan: issue one row per cycle, evaluate each row in the cycle after its issue
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         eval_vld_ff <= 1'b0;
      end else begin
         if (cmd.complete) begin
            scan_cnt_ff <= '0;
         end else if (scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + (IDX_W + 1)'(1);
         end
         eval_vld_ff <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) eval_idx_ff <= scan_cnt_ff[IDX_W-1:0];
   end

   // dependent of the completed node, not done itself, all parents done
   assign scan_hit = eval_vld_ff && row[node_idx] && !mask_ff[eval_idx_ff]
                     && ((row & ~mask_ff) == '0);

   // ready queue
   assign tail     = head_ff + fill_ff[QUEUE_AW-1:0];
   assign push_req = cmd.enq_src || scan_hit;
   assign push_id  = cmd.enq_src ? node_ff : NODE_W'(eval_idx_ff);
   assign push_ok  = push_req && (fill_ff < QUEUE_FW'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push_ok) queue_mem[tail] <= push_id;
      if (cmd.pop) q_rdata_ff <= queue_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.pop) begin
         head_ff <= head_ff + QUEUE_AW'(1);
         fill_ff <= fill_ff - QUEUE_FW'(1);
      end else if (push_ok) begin
         fill_ff <= fill_ff + QUEUE_FW'(1);
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_vld_ff <= 1'b0;
         pushed_ff   <= '0;
         err_ff      <= ERR_OK;
      end else if (cmd.load) begin
         disp_vld_ff <= 1'b0;
         pushed_ff   <= '0;
         err_ff      <= ERR_OK;
      end else begin
         if (cmd.pop)      disp_vld_ff <= 1'b1;
         if (push_ok)      pushed_ff   <= pushed_ff + PUSHED_W'(1);
         if (cmd.err_load) err_ff      <= cmd.err_code;
      end
   end

   assign status.kind          = kind_ff;
   assign status.in_range      = (int'(node_ff) < MAX_NODES);
   assign status.edge_in_range = (int'(node_ff) < MAX_NODES) && (int'(parent_ff) < MAX_NODES);
   assign status.node_done     = status.in_range && mask_ff[node_idx];
   assign status.queue_empty   = (fill_ff == '0);
   assign status.scan_done     = (scan_cnt_ff == SCAN_END) && !eval_vld_ff;

   assign rsp_dispatch_valid = disp_vld_ff;
   assign rsp_dispatch_node  = disp_vld_ff ? q_rdata_ff : '0;
   assign rsp_pushed_count   = pushed_ff;
   assign rsp_all_done       = (CMP_W'(count_ff) >= CMP_W'(active_nodes));
   assign rsp_error          = err_ff;

endmodule
`default_nettype wire

// ----- src/dependency_ready_dispatcher_core.sv -----
// after decode: add edge reads then writes the row, start source enqueues, pop reads the queue,
//   completion marks done and scans all rows; out-of-range or error requests go to the strobe
// throughput: one request at a time, the next can be taken in the cycle after the strobe;
//   the completion scan reads one matrix row per cycle
// reset: synchronous, active high; clears graph rows (by valid bits), done mask, counts, queue
// the result is shown for one cycle on rsp_strobe; the receiver cannot stall it
`default_nettype none
module dependency_ready_dispatcher_core #(
   parameter int MAX_NODES = drd_pkg::MAX_NODES_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               start,
   output logic                              busy,
   input  wire [drd_pkg::KIND_W-1:0]         req_kind,
   input  wire [drd_pkg::NODE_W-1:0]         req_node,
   input  wire [drd_pkg::NODE_W-1:0]         req_parent_node,
   // result channel
   output logic                              rsp_strobe,
   output logic                              rsp_dispatch_valid,
   output logic [drd_pkg::NODE_W-1:0]        rsp_dispatch_node,
   output logic [drd_pkg::PUSHED_W-1:0]      rsp_pushed_count,
   output logic                              rsp_all_done,
   output logic [drd_pkg::ERR_W-1:0]         rsp_error,
   // configuration port
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [drd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [drd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [drd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import drd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // active node count register
   logic [ACTIVE_W-1:0] active_ff;
   logic                csr_wr;
   logic                csr_sel_active;

   assign csr_pready     = 1'b1;
   assign csr_sel_active = (csr_paddr[2] == REG_ACTIVE_NODES);
   assign csr_wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr && csr_sel_active) begin
         active_ff <= csr_pwdata[ACTIVE_W-1:0];
      end
   end

   // reads outside the register list return zero
   assign csr_prdata = csr_sel_active ? CSR_DATA_W'(active_ff) : '0;

   // sequencer: decodes each request and steps the datapath through it
   drd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // parent matrix, done mask, scan pipeline, ready queue and result fields
   drd_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_node           (req_node),
      .req_parent_node    (req_parent_node),
      .active_nodes       (active_ff),
      .rsp_dispatch_valid (rsp_dispatch_valid),
      .rsp_dispatch_node  (rsp_dispatch_node),
      .rsp_pushed_count   (rsp_pushed_count),
      .rsp_all_done       (rsp_all_done),
      .rsp_error          (rsp_error)
   );

endmodule
`default_nettype wire

// ----- tb/dependency_ready_dispatcher_core_test.sv -----
`timescale 1ns / 100ps
module dependency_ready_dispatcher_core_test;
   import drd_pkg::*;

   localparam int NODES       = MAX_NODES_DEFAULT;
   localparam int REQ_TARGET  = 1600;
   localparam int CALM_TAIL   = 200;      // last requests go out back to back
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_WAIT = 60;       // longer than the slowest completion scan
   localparam logic [CSR_ADDR_W-1:0] ACTIVE_NODES_ADDR = {REG_ACTIVE_NODES, 2'b00};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] parent;
   } graph_req_type;

   typedef struct packed {
      logic                dispatch_valid;
      logic [NODE_W-1:0]   dispatch_node;
      logic [PUSHED_W-1:0] pushed_count;
      logic                all_done;
      logic [ERR_W-1:0]    error;
   } dispatch_rsp_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request channel
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [NODE_W-1:0]   req_node = '0;
   logic [NODE_W-1:0]   req_parent_node = '0;

   // result channel
   logic                rsp_strobe;
   logic                rsp_dispatch_valid;
   logic [NODE_W-1:0]   rsp_dispatch_node;
   logic [PUSHED_W-1:0] rsp_pushed_count;
   logic                rsp_all_done;
   logic [ERR_W-1:0]    rsp_error;

   // register port
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dependency_ready_dispatcher_core #(.MAX_NODES(NODES)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_node(req_node),
      .req_parent_node(req_parent_node),
      .rsp_strobe(rsp_strobe),
      .rsp_dispatch_valid(rsp_dispatch_valid),
      .rsp_dispatch_node(rsp_dispatch_node),
      .rsp_pushed_count(rsp_pushed_count),
      .rsp_all_done(rsp_all_done),
      .rsp_error(rsp_error),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // scheduler mirror: parent rows, done mask and count, ready fifo, node count
   logic [NODES-1:0]    graph_rows [NODES] = '{default: '0};
   logic [NODES-1:0]    done_mask = '0;
   logic [ACTIVE_W-1:0] done_count = '0;
   logic [ACTIVE_W-1:0] node_limit = ACTIVE_RESET;
   logic [NODE_W-1:0]   ready_fifo [$];

   graph_req_type    req_backlog [$];      // requests waiting for the driver
   dispatch_rsp_type awaited_rsp [$];      // predicted results, oldest first
   graph_req_type    cur_req;
   bit               idle_on = 1'b0;
   int               gap_left = 0;

   int planned_cnt = 0;
   int accepted_cnt = 0;
   int checked_cnt = 0;
   int fail_cnt = 0;
   int cycle_cnt = 0;
   int drop_cnt = 0;
   int max_burst = 0;
   int cfg_writes = 0;

   // append to the ready fifo; a full fifo drops the id, which is not counted as pushed
   function automatic logic fifo_push(input logic [NODE_W-1:0] id);
      if (ready_fifo.size() >= QUEUE_DEPTH) begin
         drop_cnt++;
         return 1'b0;
      end
      ready_fifo.insert(ready_fifo.size(), id);
      return 1'b1;
   endfunction

   // apply one request to the mirror and return the dispatch it must produce
   function automatic dispatch_rsp_type schedule_step(input graph_req_type r);
      dispatch_rsp_type o;
      o = '0;
      // node ids are 5 bits and the graph has 32 rows, so every id is in range
      case (r.kind)
         KIND_ADD_EDGE: begin
            graph_rows[r.node][r.parent] = 1'b1;
         end
         KIND_START: begin
            o.pushed_count = PUSHED_W'(fifo_push(r.node));
         end
         KIND_COMPLETE: begin
            if (done_mask[r.node]) begin
               o.error = ERR_DONE;
            end else begin
               done_mask[r.node] = 1'b1;
               done_count = done_count + 1'b1;
               // dependents in ascending order; a done dependent is never requeued
               for (int c = 0; c < NODES; c++) begin
                  if (graph_rows[c][r.node] && !done_mask[c] &&
                      (graph_rows[c] & ~done_mask) == '0)
                     o.pushed_count = o.pushed_count + PUSHED_W'(fifo_push(NODE_W'(c)));
               end
            end
         end
         default: begin
            if (ready_fifo.size() == 0) begin
               o.error = ERR_EMPTY;
            end else begin
               o.dispatch_valid = 1'b1;
               o.dispatch_node = ready_fifo.pop_front();
            end
         end
      endcase
      // a node count of zero reads as all done from the start
      o.all_done = (done_count >= node_limit);
      return o;
   endfunction

   // driver: holds a request until it is taken, random idle bursts in between
   always @(posedge clock) begin
      dispatch_rsp_type fresh;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            fresh = schedule_step(cur_req);
            if (int'(fresh.pushed_count) > max_burst) max_burst = int'(fresh.pushed_count);
            awaited_rsp.insert(awaited_rsp.size(), fresh);
            accepted_cnt++;
         end
         if (!start || !busy) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               start <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               // idle for this cycle and for the rest of the burst
               gap_left <= $urandom_range(0, 14);
               start <= 1'b0;
            end else begin
               cur_req = req_backlog.pop_front();
               req_kind <= cur_req.kind;
               req_node <= cur_req.node;
               req_parent_node <= cur_req.parent;
               start <= 1'b1;
            end
         end
      end
   end

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_cnt++;
      end
   endtask

   // monitor: every strobe is matched against the oldest prediction
   always @(posedge clock) begin
      dispatch_rsp_type want;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d of %0d requests taken, %0d results outstanding",
                  $time, accepted_cnt, planned_cnt, awaited_rsp.size());
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual node %0d error %0d",
                     $time, rsp_dispatch_node, rsp_error);
            fail_cnt++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("dispatch_valid", want.dispatch_valid, rsp_dispatch_valid);
            check_field("dispatch_node", want.dispatch_node, rsp_dispatch_node);
            check_field("pushed_count", want.pushed_count, rsp_pushed_count);
            check_field("all_done", want.all_done, rsp_all_done);
            check_field("error", want.error, rsp_error);
            checked_cnt++;
         end
      end
   end

   function automatic logic [NODE_W-1:0] rnd_node();
      return NODE_W'($urandom);
   endfunction

   task automatic queue_req(input logic [KIND_W-1:0] k, input logic [NODE_W-1:0] n,
                            input logic [NODE_W-1:0] p);
      graph_req_type r;
      r.kind = k;
      r.node = n;
      r.parent = p;
      req_backlog.insert(req_backlog.size(), r);
      planned_cnt++;
   endtask

   // wait at falling edges until every request is taken and answered
   task automatic drain();
      @(negedge clock);
      while (req_backlog.size() != 0 || start || busy || awaited_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [ACTIVE_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ACTIVE_NODES_ADDR;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // access phase completed at this edge, the register now holds the value
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      node_limit = value;
      cfg_writes++;
      @(negedge clock);
   endtask

   task automatic csr_read_check();
      logic [CSR_DATA_W-1:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr <= ACTIVE_NODES_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got[ACTIVE_W-1:0] != node_limit) begin
         $display("%0t: active_nodes readback mismatch, expected %0d, actual %0d",
                  $time, node_limit, got[ACTIVE_W-1:0]);
         fail_cnt++;
      end
      @(negedge clock);
   endtask

   task automatic mix(ref int q[$]);
      int j;
      int t;
      for (int i = q.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = q[i];
         q[i] = q[j];
         q[j] = t;
      end
   endtask

   // a node that may run now, else any unfinished one, else anything
   function automatic logic [NODE_W-1:0] pick_source();
      logic [NODE_W-1:0] cands [$];
      for (int c = 0; c < NODES; c++)
         if (!done_mask[c] && (graph_rows[c] & ~done_mask) == '0)
            cands.insert(cands.size(), NODE_W'(c));
      if (cands.size() == 0)
         for (int c = 0; c < NODES; c++)
            if (!done_mask[c]) cands.insert(cands.size(), NODE_W'(c));
      if (cands.size() == 0) return rnd_node();
      return cands[$urandom_range(0, cands.size() - 1)];
   endfunction

   // random dag over the unfinished nodes: one hub feeding about half of them,
   // a few extra parents taken from earlier in a random order
   task automatic plan_graph();
      int order [$];
      int links [$];
      for (int c = 0; c < NODES; c++)
         if (!done_mask[c]) order.insert(order.size(), c);
      mix(order);
      for (int i = 1; i < order.size(); i++) begin
         if ($urandom_range(0, 1) == 1)
            links.insert(links.size(), order[i] * NODES + order[0]);
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2))
               links.insert(links.size(),
                            order[i] * NODES + order[$urandom_range(0, i - 1)]);
      end
      mix(links);
      foreach (links[i])
         queue_req(KIND_ADD_EDGE, NODE_W'(links[i] / NODES), NODE_W'(links[i] % NODES));
   endtask

   // one worker round: maybe flood the fifo, pop a few ids, complete what was popped
   task automatic plan_round();
      logic [NODE_W-1:0] plan_q [$];
      logic [NODE_W-1:0] grabbed [$];
      logic [NODE_W-1:0] pick;
      int spare;
      int take;
      plan_q = ready_fifo;
      if ($urandom_range(0, 5) == 0) begin
         // run the fifo into its full state, the last starts get dropped
         spare = QUEUE_DEPTH - plan_q.size() + $urandom_range(1, 3);
         repeat (spare) begin
            pick = rnd_node();
            queue_req(KIND_START, pick, rnd_node());
            if (plan_q.size() < QUEUE_DEPTH) plan_q.insert(plan_q.size(), pick);
         end
      end
      if (plan_q.size() == 0) begin
         pick = pick_source();
         queue_req(KIND_START, pick, rnd_node());
         plan_q.insert(plan_q.size(), pick);
      end
      take = $urandom_range(1, (plan_q.size() < 6) ? plan_q.size() : 6);
      repeat (take) begin
         queue_req(KIND_POP, rnd_node(), rnd_node());
         grabbed.insert(grabbed.size(), plan_q.pop_front());
      end
      foreach (grabbed[i]) queue_req(KIND_COMPLETE, grabbed[i], rnd_node());
      // stray requests of any kind: early completions, extra edges, extra starts, pops on an empty fifo
      if ($urandom_range(0, 3) == 0) queue_req(KIND_W'($urandom), rnd_node(), rnd_node());
   endtask

   initial begin
      int round;
      int pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      csr_read_check();

      // directed requests at the reset node count
      queue_req(KIND_POP, 5'd0, 5'd0);            // empty fifo
      queue_req(KIND_START, 5'd31, 5'd31);
      queue_req(KIND_START, 5'd0, 5'd0);
      queue_req(KIND_POP, 5'd31, 5'd0);
      queue_req(KIND_POP, 5'd0, 5'd31);
      queue_req(KIND_ADD_EDGE, 5'd31, 5'd0);      // extreme ids, both ways round
      queue_req(KIND_ADD_EDGE, 5'd0, 5'd31);
      queue_req(KIND_COMPLETE, 5'd30, 5'd0);      // no dependents
      queue_req(KIND_COMPLETE, 5'd30, 5'd0);      // completed twice
      queue_req(KIND_ADD_EDGE, 5'd29, 5'd29);     // self edge
      queue_req(KIND_ADD_EDGE, 5'd29, 5'd28);
      queue_req(KIND_COMPLETE, 5'd28, 5'd0);      // self edge keeps 29 waiting
      queue_req(KIND_START, 5'd29, 5'd0);         // only a start can run it
      queue_req(KIND_POP, 5'd0, 5'd0);
      queue_req(KIND_ADD_EDGE, 5'd30, 5'd27);     // dependent already done
      queue_req(KIND_COMPLETE, 5'd27, 5'd0);
      queue_req(KIND_ADD_EDGE, 5'd25, 5'd24);
      queue_req(KIND_START, 5'd25, 5'd0);
      queue_req(KIND_COMPLETE, 5'd24, 5'd0);      // 25 queued a second time
      queue_req(KIND_POP, 5'd0, 5'd0);
      queue_req(KIND_POP, 5'd0, 5'd0);
      queue_req(KIND_ADD_EDGE, 5'd21, 5'd10);
      queue_req(KIND_POP, 5'd0, 5'd0);
      drain();

      plan_graph();
      drain();

      // worker rounds with a node count change every dozen rounds
      round = 0;
      while (planned_cnt < REQ_TARGET) begin
         if (round % 12 == 0) begin
            pick = (round / 12) % 5;
            case (pick)
               0: csr_write(6'd1);
               1: csr_write(6'd0);
               2: csr_write(6'd63);
               3: csr_write(6'd32);
               default: csr_write(ACTIVE_W'($urandom_range(2, 31)));
            endcase
            csr_read_check();
         end
         idle_on = (planned_cnt < REQ_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         plan_round();
         drain();
         round++;
      end

      idle_on = 1'b0;
      repeat (SETTLE_WAIT) @(posedge clock);
      $display("checked %0d results for %0d requests in %0d worker rounds, %0d nodes done",
               checked_cnt, accepted_cnt, round, done_count);
      $display("largest completion burst %0d, %0d fifo drops, %0d node count writes",
               max_burst, drop_cnt, cfg_writes);
      if (fail_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
